// ===== rtl/kwa_pkg.sv =====
// Shared widths, band limits and codes for the knob window attenuation block.
`default_nettype none

package kwa_pkg;

  // Field widths.
  localparam int SAMPLE_W = 9;
  localparam int CODE_W   = 8;
  localparam int TOTAL_W  = 14;

  // Default window length.
  localparam int WINDOW_LEN_DEF = 32;

  // Largest value that a sample and the reported total can hold.
  localparam int SAMPLE_MAX = 511;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 14'h3FFF;

  // Band limits on the window total.
  localparam logic [TOTAL_W-1:0] TOP_LIMIT    = 14'h3FC0;
  localparam logic [TOTAL_W-1:0] CENTRE_HIGH  = 14'h2200;
  localparam logic [TOTAL_W-1:0] CENTRE_LOW   = 14'h1E00;
  localparam logic [TOTAL_W-1:0] BOTTOM_LIMIT = 14'h0040;

  // Fixed attenuation codes.
  localparam logic [CODE_W-1:0] CODE_LOUDEST = 8'h00;
  localparam logic [CODE_W-1:0] CODE_CENTRE  = 8'h0C;
  localparam logic [CODE_W-1:0] CODE_MUTE    = 8'hFF;
  localparam logic [CODE_W-1:0] TAPER_BASE   = 8'd13;

endpackage

`default_nettype wire

// ===== rtl/knob_window_to_attenuation_top.sv =====
// Knob sample window: ring memory, running total and attenuation code mapping.
// A result in the fixed bands passes through S_READ, S_MAP1 and S_DONE; the taper band adds S_MAP2 to S_MAP4.
// One item at a time: in_ready is high only in S_IDLE, so a new beat waits until the result has left
// S_DONE, and a stalled result holds the block in S_DONE.
// Reset (rst, synchronous) clears the state, the pointer, the total and every ring valid bit,
// so that unwritten ring entries read as zero; the block accepts beats in the next cycle.
`default_nettype none

module knob_window_to_attenuation_top #(
  parameter int WINDOW_LEN = kwa_pkg::WINDOW_LEN_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [kwa_pkg::SAMPLE_W-1:0] knob_sample,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [kwa_pkg::CODE_W-1:0]        atten_code,
  output logic [kwa_pkg::TOTAL_W-1:0]       window_total
);

  localparam int PTR_W   = $clog2(WINDOW_LEN);
  localparam int RAW_W   = $clog2(WINDOW_LEN * kwa_pkg::SAMPLE_MAX + 1);
  localparam int ACC_W   = (RAW_W > kwa_pkg::TOTAL_W) ? RAW_W : kwa_pkg::TOTAL_W;
  localparam int UP_SPAN = 7616;  // TOP_LIMIT - CENTRE_HIGH

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_MAP1 = 3'd2;
  localparam logic [2:0] S_MAP2 = 3'd3;
  localparam logic [2:0] S_MAP3 = 3'd4;
  localparam logic [2:0] S_MAP4 = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]                      state;
  logic [PTR_W-1:0]                ptr;
  logic [WINDOW_LEN-1:0]           filled;
  logic [ACC_W-1:0]                total;
  logic [kwa_pkg::SAMPLE_W-1:0]    sample;
  logic [kwa_pkg::SAMPLE_W-1:0]    rdata;
  logic [kwa_pkg::TOTAL_W-1:0]     sat_total;
  logic [kwa_pkg::CODE_W-1:0]      code;
  logic [8:0]                      d;
  logic [17:0]                     sq;
  logic [13:0]                     t;

  logic [kwa_pkg::SAMPLE_W-1:0]    ring [WINDOW_LEN];

  logic                            in_beat;
  logic                            out_free;
  logic [kwa_pkg::SAMPLE_W-1:0]    old_sample;
  logic [ACC_W-1:0]                total_next;
  logic [kwa_pkg::TOTAL_W-1:0]     sat_next;
  logic [12:0]                     low_gap;
  logic [15:0]                     low_gap_x5;
  logic [12:0]                     high_gap;
  logic [16:0]                     high_gap_x12;
  logic [3:0]                      up_code;
  logic [17:0]                     sq_next;
  logic [23:0]                     sq_x125;
  logic [13:0]                     t_next;
  logic [26:0]                     t_recip;
  logic [kwa_pkg::CODE_W-1:0]      taper_code;

  assign in_ready = (state == S_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Ring memory: read of the oldest entry on the input beat, write-back in the cycle after it.
  // Only one item is in flight, so a read never overlaps a write to the same entry.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      rdata <= ring[ptr];
    end
    if (state == S_READ) begin
      ring[ptr] <= sample;
    end
  end

  // New running total and its saturated copy.
  always_comb begin
    old_sample = filled[ptr] ? rdata : '0;
    total_next = total - ACC_W'(old_sample) + ACC_W'(sample);
    if (total_next > ACC_W'(kwa_pkg::TOTAL_MAX)) begin
      sat_next = kwa_pkg::TOTAL_MAX;
    end else begin
      sat_next = total_next[kwa_pkg::TOTAL_W-1:0];
    end
  end

  // Band arithmetic: taper distance and the linear code of the upper band.
  always_comb begin
    low_gap      = 13'(kwa_pkg::CENTRE_LOW - sat_total);
    low_gap_x5   = 16'(low_gap) * 16'd5;
    high_gap     = 13'(kwa_pkg::TOP_LIMIT - sat_total);
    high_gap_x12 = 17'(high_gap) * 17'd12;
    up_code      = '0;
    for (int k = 1; k <= 11; k++) begin
      if (high_gap_x12 >= 17'(UP_SPAN * k)) begin
        up_code = up_code + 4'd1;
      end
    end
  end

  // Taper chain: square, scale, then divide by 100 through a reciprocal.
  always_comb begin
    sq_next    = 18'(d) * 18'(d);
    sq_x125    = 24'(sq) * 24'd125;
    t_next     = 14'(sq_x125 >> 10) + 14'(d) * 14'd10;
    t_recip    = 27'(t) * 27'd5243;
    taper_code = 8'(t_recip >> 19) + kwa_pkg::TAPER_BASE;
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ptr       <= '0;
      filled    <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_beat) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          total       <= total_next;
          filled[ptr] <= 1'b1;
          if (ptr == PTR_W'(WINDOW_LEN - 1)) begin
            ptr <= '0;
          end else begin
            ptr <= ptr + 1'b1;
          end
          state <= S_MAP1;
        end
        S_MAP1: begin
          if (sat_total < kwa_pkg::BOTTOM_LIMIT || sat_total >= kwa_pkg::CENTRE_LOW) begin
            state <= S_DONE;
          end else begin
            state <= S_MAP2;
          end
        end
        S_MAP2: state <= S_MAP3;
        S_MAP3: state <= S_MAP4;
        S_MAP4: state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      sample <= knob_sample;
    end
    if (state == S_READ) begin
      sat_total <= sat_next;
    end
    if (state == S_MAP1) begin
      d <= 9'(low_gap_x5 >> 7);
      if (sat_total > kwa_pkg::TOP_LIMIT) begin
        code <= kwa_pkg::CODE_LOUDEST;
      end else if (sat_total < kwa_pkg::BOTTOM_LIMIT) begin
        code <= kwa_pkg::CODE_MUTE;
      end else if (sat_total > kwa_pkg::CENTRE_HIGH) begin
        code <= 8'(up_code);
      end else begin
        code <= kwa_pkg::CODE_CENTRE;
      end
    end
    if (state == S_MAP2) begin
      sq <= sq_next;
    end
    if (state == S_MAP3) begin
      t <= t_next;
    end
    if (state == S_MAP4) begin
      code <= taper_code;
    end
    if (state == S_DONE && out_free) begin
      atten_code   <= code;
      window_total <= sat_total;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kwa_checker.sv =====
// Port-level checker for the knob window attenuation block, with its bind.
`default_nettype none

module kwa_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [kwa_pkg::CODE_W-1:0]   atten_code,
  input wire logic [kwa_pkg::TOTAL_W-1:0]  window_total
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(atten_code) && $stable(window_total))
    else $error("result beat changed while stalled");

  // A nearly empty window mutes.
  a_mute: assert property (@(posedge clk) disable iff (rst)
    out_valid && window_total < kwa_pkg::BOTTOM_LIMIT |-> atten_code == kwa_pkg::CODE_MUTE)
    else $error("low total did not mute");

  // A full-scale window gives the loudest code.
  a_loud: assert property (@(posedge clk) disable iff (rst)
    out_valid && window_total > kwa_pkg::TOP_LIMIT |-> atten_code == kwa_pkg::CODE_LOUDEST)
    else $error("high total did not give the loudest code");

  // The centre dead band gives the centre code.
  a_centre: assert property (@(posedge clk) disable iff (rst)
    out_valid && window_total >= kwa_pkg::CENTRE_LOW && window_total <= kwa_pkg::CENTRE_HIGH
    |-> atten_code == kwa_pkg::CODE_CENTRE)
    else $error("centre band gave a wrong code");

endmodule

bind knob_window_to_attenuation_top kwa_checker u_kwa_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .atten_code   (atten_code),
  .window_total (window_total)
);

`default_nettype wire
